[rtl/core/icf_pkg.sv]
// Shared types, widths, constants and tables of the complementary attitude filter.
package icf_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned CORDIC_W = 36;
   localparam int unsigned ZW = 26;
   localparam int unsigned MUL_A_W = 28;
   localparam int unsigned MUL_B_W = 18;
   localparam int unsigned MUL_P_W = 46;
   localparam int unsigned DIV_W = 52;
   localparam int unsigned DEN_W = 27;
   localparam int unsigned SQ_W = 32;

   localparam logic [ZW-1:0] DEG180 = ZW'(180 * 65536);
   localparam logic [DEN_W-1:0] DEN_DT = DEN_W'(131000000);
   localparam logic [DEN_W-1:0] DEN_RATE = DEN_W'(131);
   localparam logic [DIV_W-1:0] HALF_DT = DIV_W'(65500000);
   localparam logic [DIV_W-1:0] HALF_RATE = DIV_W'(65);
   localparam logic [17:0] DT_DEFAULT = 18'd10000;
   localparam logic [31:0] DT_LIMIT = 32'd200000;
   localparam logic [16:0] ALPHA_ONE = 17'd65536;
   localparam logic [16:0] ALPHA_RESET = 17'd64225;

   localparam logic [1:0] CSR_GYRO_X_BIAS = 2'd0;
   localparam logic [1:0] CSR_GYRO_Y_BIAS = 2'd1;
   localparam logic [1:0] CSR_BLEND_WEIGHT = 2'd2;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_SEED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQA, ST_SQB, ST_SQRT, ST_CROLL, ST_CPITCH, ST_SEED,
      ST_MDT, ST_DDT, ST_MG, ST_MACC, ST_DRATE, ST_FIN
   } state_type;

   function automatic logic [21:0] icf_atan(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0: v = 22'd2949120;
         5'd1: v = 22'd1740967;
         5'd2: v = 22'd919879;
         5'd3: v = 22'd466945;
         5'd4: v = 22'd234379;
         5'd5: v = 22'd117304;
         5'd6: v = 22'd58666;
         5'd7: v = 22'd29335;
         5'd8: v = 22'd14668;
         5'd9: v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [18:0] icf_clamp(input logic signed [24:0] v);
      logic signed [18:0] r;
      if (v > 25'sd262143) begin
         r = 19'sd262143;
      end else if (v < -25'sd262144) begin
         r = -19'sd262144;
      end else begin
         r = v[18:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/imu_complementary_attitude_filter.sv]
// Top level of the complementary roll/pitch attitude filter.
//
//   port group  direction  what it carries
//   req_*       in         one raw IMU sample per item, tuser = op
//   rsp_*       out        filtered angles and rates, one item per sample
//   csr_*       in         bias and blend weight register writes
//
// An update item runs the square root, two CORDIC passes and, per axis, three
// runs of one shared shift-add multiplier and two of a bit-serial divider, all
// one after another; a seed item stops after the two CORDIC passes.
// One item is worked on at a time; the next is taken while a result waits.
// Reset is synchronous, clears the angles and biases and restores the blend weight.
module imu_complementary_attitude_filter
   import icf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us
   input  logic [111:0]  req_tdata,
   // op
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // roll_angle_out, pitch_angle_out, roll_rate_out, pitch_rate_out, zero pad
   output logic [79:0]   rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [19:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic signed [19:0] bias_x_ff, bias_y_ff;
   logic [16:0]        weight_ff;

   logic               op_ff, axis_ff, issued_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [20:0] dx_ff, dy_ff;
   logic [17:0]        dt_ff;
   logic [16:0]        alpha_ff;
   logic [SQ_W-1:0]    sq_ff, mag_ff;
   logic signed [ZW-1:0] acc_r_ff, acc_p_ff;
   logic signed [MUL_P_W-1:0] s1_ff;
   logic signed [MUL_A_W-1:0] g_ff;
   logic [DIV_W-1:0]   dnum_ff;
   logic               dneg_ff;
   logic signed [18:0] roll_ff, pitch_ff;
   logic signed [19:0] rr_ff, pr_ff;
   logic               rsp_valid_ff;
   logic [79:0]        rsp_data_ff;

   logic accept;
   logic sqrt_start, cordic_start, mul_start, div_start;
   logic sqrt_done, cordic_done, mul_done, div_done;
   logic [SQ_W-1:0] root;
   logic signed [ZW-1:0] angle;
   logic signed [MUL_P_W-1:0] product;
   logic [DIV_W-1:0] quotient;
   logic signed [CORDIC_W-1:0] cy, cx;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [DEN_W-1:0] den;
   logic signed [15:0] sq_in;
   logic signed [31:0] sq_prod;
   logic [31:0] el;
   logic [16:0] wt;
   logic signed [20:0] diff;
   logic signed [18:0] old;
   logic signed [ZW-1:0] acc_sel;
   logic [MUL_P_W-1:0] pmag;
   logic [20:0] dmag;
   logic signed [MUL_P_W:0] sum;
   logic signed [ZW:0] seed_r, seed_p;
   logic signed [MUL_A_W-1:0] term;
   logic signed [19:0] rate;

   assign accept = req_tvalid && req_tready;
   assign el = req_tdata[111:80];
   assign wt = weight_ff;

   assign diff = axis_ff ? dy_ff : dx_ff;
   assign old = axis_ff ? pitch_ff : roll_ff;
   assign acc_sel = axis_ff ? acc_p_ff : acc_r_ff;
   assign pmag = product[MUL_P_W-1] ? MUL_P_W'(-product) : MUL_P_W'(product);
   assign dmag = diff[20] ? 21'(-diff) : 21'(diff);
   assign sum = MUL_P_W'(s1_ff) + (MUL_P_W + 1)'(product) + (MUL_P_W + 1)'(1 << 21);
   assign seed_r = (ZW + 1)'(acc_r_ff) + (ZW + 1)'(32);
   assign seed_p = (ZW + 1)'(acc_p_ff) + (ZW + 1)'(32);
   assign term = dneg_ff ? -$signed(MUL_A_W'(quotient[26:0]))
                         : $signed(MUL_A_W'(quotient[26:0]));
   assign rate = dneg_ff ? -$signed(quotient[19:0]) : $signed(quotient[19:0]);
   assign sq_in = (state_ff == ST_SQA) ? ay_ff : az_ff;
   assign sq_prod = sq_in * sq_in;

   assign cy = (state_ff == ST_CROLL) ? CORDIC_W'($signed({ay_ff, 16'b0}))
                                      : -CORDIC_W'($signed({ax_ff, 16'b0}));
   assign cx = (state_ff == ST_CROLL) ? CORDIC_W'($signed({az_ff, 16'b0}))
                                      : $signed({4'b0, mag_ff});

   always_comb begin
      mul_a = $signed({{3{old[18]}}, old, 6'b0});
      mul_b = '0;
      unique case (state_ff)
         ST_MDT: begin
            mul_a = MUL_A_W'(diff);
            mul_b = dt_ff;
         end
         ST_MG: begin
            mul_a = g_ff;
            mul_b = MUL_B_W'(alpha_ff);
         end
         ST_MACC: begin
            mul_a = MUL_A_W'(acc_sel);
            mul_b = MUL_B_W'(ALPHA_ONE - alpha_ff);
         end
         default: begin
            mul_b = '0;
         end
      endcase
   end

   assign den = (state_ff == ST_DDT) ? DEN_DT : DEN_RATE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      sqrt_start = 1'b0;
      cordic_start = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SQA;
            end
         end
         ST_SQA: state_in = ST_SQB;
         ST_SQB: state_in = ST_SQRT;
         ST_SQRT: begin
            sqrt_start = !issued_ff;
            if (sqrt_done) begin
               state_in = ST_CROLL;
            end
         end
         ST_CROLL: begin
            cordic_start = !issued_ff;
            if (cordic_done) begin
               state_in = ST_CPITCH;
            end
         end
         ST_CPITCH: begin
            cordic_start = !issued_ff;
            if (cordic_done) begin
               state_in = (op_ff == OP_SEED) ? ST_SEED : ST_MDT;
            end
         end
         ST_SEED: state_in = ST_FIN;
         ST_MDT: begin
            mul_start = !issued_ff;
            if (mul_done) begin
               state_in = ST_DDT;
            end
         end
         ST_DDT: begin
            div_start = !issued_ff;
            if (div_done) begin
               state_in = ST_MG;
            end
         end
         ST_MG: begin
            mul_start = !issued_ff;
            if (mul_done) begin
               state_in = ST_MACC;
            end
         end
         ST_MACC: begin
            mul_start = !issued_ff;
            if (mul_done) begin
               state_in = ST_DRATE;
            end
         end
         ST_DRATE: begin
            div_start = !issued_ff;
            if (div_done) begin
               state_in = axis_ff ? ST_FIN : ST_MDT;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= 1'b0;
         axis_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bias_x_ff <= '0;
         bias_y_ff <= '0;
         weight_ff <= ALPHA_RESET;
         roll_ff <= '0;
         pitch_ff <= '0;
      end else begin
         if (sqrt_start || cordic_start || mul_start || div_start) begin
            issued_ff <= 1'b1;
         end else if (sqrt_done || cordic_done || mul_done || div_done) begin
            issued_ff <= 1'b0;
         end
         if (accept) begin
            axis_ff <= 1'b0;
         end else if (state_ff == ST_DRATE && div_done) begin
            axis_ff <= 1'b1;
         end
         if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GYRO_X_BIAS: bias_x_ff <= csr_wdata;
               CSR_GYRO_Y_BIAS: bias_y_ff <= csr_wdata;
               CSR_BLEND_WEIGHT: weight_ff <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (state_ff == ST_SEED) begin
            roll_ff <= icf_clamp(25'($signed(seed_r[ZW:6])));
            pitch_ff <= icf_clamp(25'($signed(seed_p[ZW:6])));
         end else if (state_ff == ST_MACC && mul_done) begin
            if (axis_ff) begin
               pitch_ff <= icf_clamp(sum[MUL_P_W:22]);
            end else begin
               roll_ff <= icf_clamp(sum[MUL_P_W:22]);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tuser[0];
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         dx_ff <= $signed({req_tdata[63], req_tdata[63:48], 4'b0}) - 21'(bias_x_ff);
         dy_ff <= $signed({req_tdata[79], req_tdata[79:64], 4'b0}) - 21'(bias_y_ff);
         dt_ff <= (el == 32'd0 || el > DT_LIMIT) ? DT_DEFAULT : el[17:0];
         alpha_ff <= (wt > ALPHA_ONE) ? ALPHA_ONE : wt;
      end
      if (state_ff == ST_SQA) begin
         sq_ff <= 32'(sq_prod);
      end
      if (state_ff == ST_SQB) begin
         sq_ff <= sq_ff + 32'(sq_prod);
      end
      if (sqrt_done) begin
         mag_ff <= root;
      end
      if (cordic_done) begin
         if (state_ff == ST_CROLL) begin
            acc_r_ff <= angle;
         end else begin
            acc_p_ff <= angle;
         end
      end
      if (state_ff == ST_SEED) begin
         rr_ff <= '0;
         pr_ff <= '0;
      end
      if (mul_done) begin
         unique case (state_ff)
            ST_MDT: begin
               dneg_ff <= product[MUL_P_W-1];
               dnum_ff <= (DIV_W'(pmag) << 12) + HALF_DT;
            end
            ST_MG: s1_ff <= product;
            ST_MACC: begin
               dneg_ff <= diff[20];
               dnum_ff <= (DIV_W'(dmag) << 6) + HALF_RATE;
            end
            default: ;
         endcase
      end
      if (div_done) begin
         if (state_ff == ST_DDT) begin
            g_ff <= $signed({{3{old[18]}}, old, 6'b0}) + term;
         end else if (axis_ff) begin
            pr_ff <= rate;
         end else begin
            rr_ff <= rate;
         end
      end
      if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {2'b0, pr_ff, rr_ff, pitch_ff, roll_ff};
      end
   end

   icf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   icf_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .y_in  (cy),
      .x_in  (cx),
      .done  (cordic_done),
      .angle (angle)
   );

   icf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (product)
   );

   icf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (dnum_ff),
      .den      (den),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

[rtl/core/icf_sqrt.sv]
// Digit-recurrence integer square root, one result bit per cycle.
module icf_sqrt
   import icf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic              done,
   output logic [SQ_W-1:0]   root
);

   logic [2*SQ_W-1:0] n_ff;
   logic [SQ_W+2:0]   rem_ff;
   logic [SQ_W-1:0]   root_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [SQ_W+2:0]   rem2;
   logic [SQ_W+2:0]   trial;

   assign rem2 = {rem_ff[SQ_W:0], n_ff[2*SQ_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQ_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff <= {radicand, {SQ_W{1'b0}}};
         rem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         n_ff <= {n_ff[2*SQ_W-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_ff <= rem2 - trial;
            root_ff <= {root_ff[SQ_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            root_ff <= {root_ff[SQ_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/core/icf_cordic.sv]
// Iterative CORDIC in vectoring mode giving atan2 in 2^-16 degree.
module icf_cordic
   import icf_pkg::*;
#(
   parameter int unsigned STEPS = CORDIC_STEPS_DEF
)(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [CORDIC_W-1:0]  y_in,
   input  logic signed [CORDIC_W-1:0]  x_in,
   output logic                        done,
   output logic signed [ZW-1:0]        angle
);

   localparam int unsigned CNT_W = $clog2(STEPS);

   logic signed [CORDIC_W-1:0] x_ff, y_ff, xs, ys;
   logic signed [ZW-1:0]       z_ff, tab;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff, done_ff;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign tab = $signed(ZW'(icf_atan(5'(cnt_ff))));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (x_in < 0) begin
            z_ff <= (y_in >= 0) ? $signed(DEG180) : -$signed(DEG180);
            x_ff <= -x_in;
            y_ff <= -y_in;
         end else begin
            z_ff <= '0;
            x_ff <= x_in;
            y_ff <= y_in;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + tab;
         end else if (y_ff < 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - tab;
         end
      end
   end

   assign done = done_ff;
   assign angle = z_ff;

endmodule

[rtl/core/icf_mul.sv]
// Shift-add multiplier, signed by unsigned, one multiplier bit per cycle.
module icf_mul
   import icf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [MUL_A_W-1:0]  a,
   input  logic [MUL_B_W-1:0]         b,
   output logic                       done,
   output logic signed [MUL_P_W-1:0]  product
);

   logic signed [MUL_P_W-1:0] acc_ff, a_ff;
   logic [MUL_B_W-1:0]        b_ff;
   logic [4:0]                cnt_ff;
   logic                      busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff <= MUL_P_W'(a);
         b_ff <= b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff <<< 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

[rtl/core/icf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module icf_div
   import icf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0] q_ff;
   logic [DEN_W:0]   rem_ff, rem2;
   logic [DEN_W-1:0] den_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff, take;

   assign rem2 = {rem_ff[DEN_W-1:0], q_ff[DIV_W-1]};
   assign take = rem2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= take ? rem2 - {1'b0, den_ff} : rem2;
         q_ff <= {q_ff[DIV_W-2:0], take};
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

[test/tb_imu_complementary_attitude_filter.sv]
// Self-checking testbench of the complementary roll/pitch attitude filter.
module tb_imu_complementary_attitude_filter;
   import icf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam int N_RANDOM = 700;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [111:0]  req_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us
   logic [0:0]    req_tuser;   // op
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [79:0]   rsp_tdata;   // roll_angle_out, pitch_angle_out, roll_rate_out,
                               // pitch_rate_out, zero pad
   logic          csr_wr_en;
   logic [1:0]    csr_index;
   logic [19:0]   csr_wdata;

   typedef struct packed {
      logic signed [19:0] pitch_rate;
      logic signed [19:0] roll_rate;
      logic signed [18:0] pitch_angle;
      logic signed [18:0] roll_angle;
   } attitude_type;

   attitude_type attitude_q[$];

   logic signed [19:0] x_bias;
   logic signed [19:0] y_bias;
   logic [16:0]        weight;
   logic signed [18:0] roll_est;
   logic signed [18:0] pitch_est;

   longint cycle_count;
   int     n_errors;
   int     n_sent;
   int     n_checked;
   int     n_seeds;
   int     stall_left;
   bit     pace_on;

   imu_complementary_attitude_filter u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("imu_complementary_attitude_filter verification failed");
         $finish;
      end
   end

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, nx, ny, step;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         if (y == 0) break;
         step = longint'(icf_atan(i[4:0]));
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z = z + step;
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z = z - step;
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   function automatic logic signed [18:0] saturate(longint v);
      if (v > 262143) return 19'sd262143;
      if (v < -262144) return -19'sd262144;
      return v[18:0];
   endfunction

   function automatic logic signed [18:0] fuse(longint old, longint diff, longint dt,
                                               longint acc, longint alpha);
      longint g, sum;
      g = old * 64 + round_div(diff * 4096 * dt, 131000000);
      sum = alpha * g + (65536 - alpha) * acc;
      return saturate((sum + (longint'(1) << 21)) >>> 22);
   endfunction

   function automatic attitude_type predict_attitude(logic op, logic [111:0] d);
      attitude_type r;
      longint ax, ay, az, gx, gy, dt, alpha, mag, acc_roll, acc_pitch, dx, dy;
      longint unsigned el;
      ax = longint'($signed(d[15:0]));
      ay = longint'($signed(d[31:16]));
      az = longint'($signed(d[47:32]));
      gx = longint'($signed(d[63:48]));
      gy = longint'($signed(d[79:64]));
      el = d[111:80];
      dt = (el == 0 || el > 200000) ? 10000 : longint'(el);
      alpha = (weight > ALPHA_ONE) ? 65536 : longint'(weight);
      mag = int_sqrt(longint'(ay * ay + az * az) << 32);
      acc_roll = vector_angle(ay * 65536, az * 65536);
      acc_pitch = vector_angle(-ax * 65536, mag);
      dx = gx * 16 - longint'(x_bias);
      dy = gy * 16 - longint'(y_bias);
      r = '0;
      if (op == OP_SEED) begin
         roll_est = saturate((acc_roll + 32) >>> 6);
         pitch_est = saturate((acc_pitch + 32) >>> 6);
      end else begin
         r.roll_rate = 20'(round_div(dx * 64, 131));
         r.pitch_rate = 20'(round_div(dy * 64, 131));
         roll_est = fuse(longint'(roll_est), dx, dt, acc_roll, alpha);
         pitch_est = fuse(longint'(pitch_est), dy, dt, acc_pitch, alpha);
      end
      r.roll_angle = roll_est;
      r.pitch_angle = pitch_est;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      n_errors++;
      $display("mismatch on result %0d: %s got %0d, expected %0d",
               n_checked, field, got, want);
   endtask

   always @(posedge clock) begin
      attitude_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[77:0];
         if (attitude_q.size() == 0) begin
            n_errors++;
            $display("unexpected result %h", rsp_tdata);
         end else begin
            want = attitude_q.pop_front();
            if (got.roll_angle !== want.roll_angle)
               report_mismatch("roll_angle", got.roll_angle, want.roll_angle);
            if (got.pitch_angle !== want.pitch_angle)
               report_mismatch("pitch_angle", got.pitch_angle, want.pitch_angle);
            if (got.roll_rate !== want.roll_rate)
               report_mismatch("roll_rate", got.roll_rate, want.roll_rate);
            if (got.pitch_rate !== want.pitch_rate)
               report_mismatch("pitch_rate", got.pitch_rate, want.pitch_rate);
            if (rsp_tdata[79:78] !== 2'b00)
               report_mismatch("pad", rsp_tdata[79:78], 0);
         end
         n_checked++;
         stall_left = pace_on ? $urandom_range(0, 15) : 0;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(logic op, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic signed [15:0] gx,
                              logic signed [15:0] gy, logic [31:0] el);
      int gap;
      logic [111:0] d;
      gap = pace_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      d = {el, gy, gx, az, ay, ax};
      req_tdata <= d;
      req_tuser <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      attitude_q.push_back(predict_attitude(op, d));
      n_sent++;
      if (op == OP_SEED) n_seeds++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (attitude_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [19:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GYRO_X_BIAS: x_bias = value;
         CSR_GYRO_Y_BIAS: y_bias = value;
         CSR_BLEND_WEIGHT: weight = value[16:0];
         default: ;
      endcase
   endtask

   task automatic send_random(int op_pct, bit wide);
      logic op;
      logic [31:0] el;
      op = ($urandom_range(0, 99) < op_pct) ? OP_SEED : OP_UPDATE;
      case ($urandom_range(0, 3))
         0: el = $urandom;
         1: el = $urandom_range(0, 3) == 0 ? 32'd0 : 32'd200000 + $urandom_range(0, 2);
         default: el = $urandom_range(1, 200000);
      endcase
      if (wide)
         send_sample(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), el);
      else
         send_sample(op, 16'($signed($urandom_range(0, 8000)) - 4000),
                     16'($signed($urandom_range(0, 8000)) - 4000),
                     16'($signed($urandom_range(0, 8000)) + 12384),
                     16'($signed($urandom_range(0, 4000)) - 2000),
                     16'($signed($urandom_range(0, 4000)) - 2000), el);
   endtask

   task automatic test_directed();
      pace_on = 1'b0;
      send_sample(OP_SEED, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'd10000);
      send_sample(OP_UPDATE, 16'sd0, 16'sd0, 16'sd16384, 16'sd131, -16'sd131, 32'd1000);
      send_sample(OP_UPDATE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0);
      send_sample(OP_SEED, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd1);
      send_sample(OP_SEED, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 32'd1);
      send_sample(OP_UPDATE, 16'sd0, 16'sd0, -16'sd100, 16'sd5, 16'sd5, 32'd200000);
      send_sample(OP_UPDATE, 16'sd0, 16'sd0, -16'sd100, 16'sd5, 16'sd5, 32'd200001);
      send_sample(OP_UPDATE, 16'sd0, 16'sd0, -16'sd100, 16'sd5, 16'sd5, 32'hFFFFFFFF);
      send_sample(OP_UPDATE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd200000);
      send_sample(OP_UPDATE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd200000);
      send_sample(OP_SEED, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'd5);
      send_sample(OP_SEED, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd5);
      for (int i = 0; i < 6; i++)
         send_sample(OP_UPDATE, 16'h8000, 16'h7FFF, 16'sd0, 16'h7FFF, 16'h7FFF, 32'd200000);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      logic [19:0] weights[5];
      weights = '{20'd0, 20'd65536, 20'd65537, 20'h1FFFF, 20'hFFFFF};
      pace_on = 1'b1;
      for (int i = 0; i < 5; i++) begin
         write_csr(CSR_GYRO_X_BIAS, (i % 2) ? 20'h7FFFF : 20'h80000);
         write_csr(CSR_GYRO_Y_BIAS, (i % 2) ? 20'h80000 : 20'h7FFFF);
         write_csr(CSR_BLEND_WEIGHT, weights[i]);
         write_csr(2'd3, 20'($urandom));
         send_sample(OP_UPDATE, 16'sd100, 16'sd200, 16'sd16000, 16'h7FFF, 16'h8000,
                     32'd200000);
         send_sample(OP_UPDATE, 16'h8000, 16'h7FFF, 16'sd0, 16'h8000, 16'h7FFF, 32'd777);
         send_random(10, 1'b1);
         wait_idle();
      end
      write_csr(CSR_GYRO_X_BIAS, 20'd0);
      write_csr(CSR_GYRO_Y_BIAS, 20'd0);
      write_csr(CSR_BLEND_WEIGHT, {3'b0, ALPHA_RESET});
   endtask

   task automatic test_random_phases();
      int done;
      done = 0;
      while (done < N_RANDOM) begin
         pace_on = $urandom_range(0, 3) != 0;
         write_csr(CSR_GYRO_X_BIAS, 20'($urandom_range(0, 3) == 0 ? $urandom
                                  : 20'($signed($urandom_range(0, 4000)) - 2000)));
         write_csr(CSR_GYRO_Y_BIAS, 20'($urandom_range(0, 3) == 0 ? $urandom
                                  : 20'($signed($urandom_range(0, 4000)) - 2000)));
         write_csr(CSR_BLEND_WEIGHT, 20'($urandom_range(0, 3) == 0
                                         ? $urandom_range(0, 131071)
                                         : $urandom_range(60000, 65536)));
         for (int i = 0; i < 70; i++) begin
            send_random(8, $urandom_range(0, 2) == 0);
            done++;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      n_errors = 0;
      n_sent = 0;
      n_checked = 0;
      n_seeds = 0;
      stall_left = 0;
      pace_on = 1'b0;
      x_bias = '0;
      y_bias = '0;
      weight = ALPHA_RESET;
      roll_est = '0;
      pitch_est = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_register_extremes();
      test_random_phases();
      wait_idle();
      $display("sent %0d samples (%0d seeds), checked %0d results over %0d cycles",
               n_sent, n_seeds, n_checked, cycle_count);
      $display("covered bias and blend weight extremes, bad elapsed times and saturation");
      if (n_errors == 0 && attitude_q.size() == 0)
         $display("imu_complementary_attitude_filter verification clean");
      else
         $display("imu_complementary_attitude_filter verification failed");
      $finish;
   end

endmodule
